>>> rtl/core/spectral_tone_set_detector_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spectral tone set detector
// Implication checks with a clock and an active-low reset.
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_TONE_SET_DETECTOR_MACROS_SVH
`define SPECTRAL_TONE_SET_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Consequent holds in the same cycle as the antecedent.
`define STSD_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("stsd: same-cycle check failed");
// Consequent holds in the cycle after the antecedent.
`define STSD_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("stsd: next-cycle check failed");
`else
`define STSD_ASSERT_IMP(label, ck, rn, ante, cons)
`define STSD_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

>>> rtl/core/stsd_pkg.sv
// ----------------------------------------------------------------------------
// stsd_pkg
// Types and constants shared by the spectral tone set detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stsd_pkg;

    localparam int MAG_W      = 17;
    localparam int SUM_W      = 28;
    localparam int RADICAND_W = 32;
    localparam int NUM_W      = 30;
    localparam int DEN_W      = 31;
    localparam int QUOT_W     = 30;
    localparam int TONE_W     = 11;
    localparam int TONE_N     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 55;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FIRST    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LAST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TONE_BINS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TONE_BINS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_COUNT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MODE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_MODE       = 3'd7;

    localparam logic [1:0] MODE_X15 = 2'd2;
    localparam logic [1:0] MODE_X25 = 2'd3;

    typedef struct packed {
        logic signed [15:0] bin_real;
        logic signed [15:0] bin_imag;
        logic               last_bin;
    } bin_t;

    typedef struct packed {
        logic              start_found;
        logic signed [7:0] deviation;
        logic              stop_found;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RE,
        ST_MUL_IM,
        ST_ROOT,
        ST_SETUP,
        ST_AIM,
        ST_ADDR,
        ST_USE,
        ST_CMP,
        ST_DEN,
        ST_NUM,
        ST_DIV,
        ST_DIVW,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_CHECK,
        PH_STOP
    } phase_t;

endpackage

`default_nettype wire

>>> rtl/core/stsd_isqrt.sv
// ----------------------------------------------------------------------------
// stsd_isqrt
// Integer square root of a 32-bit value, two result bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stsd_isqrt (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [stsd_pkg::RADICAND_W-1:0]    value,
    output logic                                    done,
    output logic [stsd_pkg::MAG_W-1:0]              root
);

    logic [stsd_pkg::RADICAND_W-1:0] v_reg;
    logic [stsd_pkg::RADICAND_W-1:0] r_reg;
    logic [stsd_pkg::RADICAND_W-1:0] bit_reg;
    logic [2:0]                      count_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [stsd_pkg::RADICAND_W-1:0] v1, r1, v2, r2, t1, t2, bit2;

    always_comb
    begin
        t1 = r_reg + bit_reg;
        if (v_reg >= t1)
        begin
            v1 = v_reg - t1;
            r1 = (r_reg >> 1) + bit_reg;
        end
        else
        begin
            v1 = v_reg;
            r1 = r_reg >> 1;
        end
        bit2 = bit_reg >> 2;
        t2   = r1 + bit2;
        if (v1 >= t2)
        begin
            v2 = v1 - t2;
            r2 = (r1 >> 1) + bit2;
        end
        else
        begin
            v2 = v1;
            r2 = r1 >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 3'd1;
                if (count_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            r_reg   <= '0;
            bit_reg <= 32'h4000_0000;
        end
        else if (busy_reg)
        begin
            v_reg   <= v2;
            r_reg   <= r2;
            bit_reg <= bit_reg >> 4;
        end
    end

    assign done = done_reg;
    assign root = r_reg[stsd_pkg::MAG_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/stsd_div.sv
// ----------------------------------------------------------------------------
// stsd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stsd_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [stsd_pkg::NUM_W-1:0]     num,
    input  wire logic [stsd_pkg::DEN_W-1:0]     den,
    output logic                                done,
    output logic [stsd_pkg::QUOT_W-1:0]         quot
);

    logic [stsd_pkg::DEN_W:0]    rem_reg;
    logic [stsd_pkg::DEN_W-1:0]  den_reg;
    logic [stsd_pkg::QUOT_W-1:0] q_reg;
    logic [4:0]                  count_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [stsd_pkg::DEN_W:0]    rem_shift;
    logic                        fits;

    always_comb
    begin
        rem_shift = {rem_reg[stsd_pkg::DEN_W-1:0], q_reg[stsd_pkg::QUOT_W-1]};
        fits      = rem_shift >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 5'd1;
                if (count_reg == 5'(stsd_pkg::QUOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            q_reg   <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            q_reg   <= {q_reg[stsd_pkg::QUOT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

>>> rtl/core/spectral_tone_set_detector.sv
// ----------------------------------------------------------------------------
// spectral_tone_set_detector
// Stores bin magnitudes of one FFT frame and runs the start and stop tone
// tests when the last bin arrives.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  bin       in         bin_valid / bin_stall   stsd_pkg::bin_t
//  result    out        result_valid / stall    stsd_pkg::result_t
//  cfg       in         cfg_we                  cfg_index, cfg_data
//
// Bins stall while the square root unit (two bits a cycle) handles the one before.
// After the last bin, each magnitude memory read takes the aim, address and use
// states, index wraps add address steps, and up to five divides follow. Reset
// clears state, counters and the sum and loads config defaults; the magnitude
// memory is not. A stalled result holds its register and holds up the next one.
`default_nettype none

`include "spectral_tone_set_detector_macros.svh"

module spectral_tone_set_detector #(
    parameter int MAX_BINS   = 2048,
    parameter int MAX_SEARCH = 128
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                bin_valid,
    output logic                                     bin_stall,
    input  wire stsd_pkg::bin_t                      bin,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output stsd_pkg::result_t                        result,
    input  wire logic                                cfg_we,
    input  wire logic [stsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [stsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW  = $clog2(MAX_BINS);
    localparam int CW  = (AW > 11) ? AW : 11;
    localparam int PW  = $clog2(MAX_SEARCH + 1);
    localparam int XW  = 14;
    localparam int ACC_W = 20;

    // Configuration registers
    logic [10:0]       wf_reg, wl_reg;
    logic [54:0]       start_tones_reg, stop_tones_reg;
    logic [6:0]        search_low_reg;
    logic [7:0]        search_count_reg;
    logic [1:0]        start_mode_reg, stop_mode_reg;

    stsd_pkg::state_t  state_reg, state_next;
    stsd_pkg::phase_t  phase_reg;

    logic [AW-1:0]                     cnt_reg;
    logic [stsd_pkg::SUM_W-1:0]        sum_reg;
    logic                              out_valid_reg;
    stsd_pkg::result_t                 out_data_reg;

    logic signed [15:0]                re_reg, im_reg;
    logic                              last_reg;
    logic [stsd_pkg::RADICAND_W-1:0]   pw_reg;

    logic [12:0]                       n2_reg, n2m_reg;
    logic                              big_n_reg;
    logic                              win_ok_reg;
    logic [30:0]                       s_cs_reg;
    logic [28:0]                       red_reg;
    logic [PW-1:0]                     cnt_eff_reg, pos_reg, best_pos_reg;
    logic [2:0]                        k_reg;
    logic [1:0]                        j_reg;
    logic [ACC_W-1:0]                  acc_reg, best_reg;
    logic [2:0]                        hits_reg;
    logic [XW-1:0]                     x_reg;
    logic [29:0]                       prod_reg;
    logic [stsd_pkg::MAG_W-1:0]        stop_mag [stsd_pkg::TONE_N];
    logic [stsd_pkg::DEN_W-1:0]        den_reg;
    logic [stsd_pkg::NUM_W-1:0]        num_reg;
    logic [32:0]                       total_reg;
    logic                              fail_reg;
    logic                              stop_ok_reg;

    logic [stsd_pkg::MAG_W-1:0]        mag_mem [MAX_BINS];
    logic [stsd_pkg::MAG_W-1:0]        rd_data_reg;

    // Control strobes
    logic                              root_start, root_done;
    logic [stsd_pkg::MAG_W-1:0]        root;
    logic                              div_start, div_done;
    logic [stsd_pkg::QUOT_W-1:0]       quot;
    logic                              rd_en, wr_en, done_fire;

    logic signed [15:0]                mul_a;
    logic signed [31:0]                sq;
    logic                              in_window, win_ok;
    logic [11:0]                       n12;
    logic [8:0]                        sc9, cnt_eff9;
    logic [XW-1:0]                     sl14, x_calc;
    logic [10:0]                       tone_sel;
    logic [PW-1:0]                     pos_sel;
    logic [ACC_W-1:0]                  sum5;
    logic [32:0]                       total_next;
    logic                              fail_next;
    logic [2:0]                        need;
    logic                              start_ok;
    logic [9:0]                        dev10;
    logic                              red_pos;

    function automatic logic [30:0] scale_mul(input logic [28:0] v, input logic [1:0] mode);
        logic [30:0] w;
        begin
            w = 31'(v);
            case (mode)
                stsd_pkg::MODE_X15: scale_mul = (w << 1) + w;
                stsd_pkg::MODE_X25: scale_mul = (w << 2) + w;
                default:            scale_mul = w << 1;
            endcase
        end
    endfunction

    stsd_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (pw_reg + 32'(sq)),
        .done  (root_done),
        .root  (root)
    );

    stsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    always_comb
    begin
        mul_a     = (state_reg == stsd_pkg::ST_MUL_RE) ? re_reg : im_reg;
        sq        = mul_a * mul_a;
        in_window = (CW'(cnt_reg) >= CW'(wf_reg)) && (CW'(cnt_reg) <= CW'(wl_reg));
        win_ok    = wf_reg <= wl_reg;
        n12       = 12'(wl_reg) - 12'(wf_reg) + 12'd1;
        sc9       = {1'b0, search_count_reg};
        if (sc9 == 9'd0)
            cnt_eff9 = 9'd1;
        else if (sc9 > 9'(MAX_SEARCH))
            cnt_eff9 = 9'(MAX_SEARCH);
        else
            cnt_eff9 = sc9;

        sl14    = {{(XW-7){search_low_reg[6]}}, search_low_reg};
        pos_sel = (phase_reg == stsd_pkg::PH_CHECK) ? best_pos_reg : pos_reg;
        if (phase_reg == stsd_pkg::PH_STOP)
        begin
            tone_sel = stop_tones_reg[11*k_reg +: 11];
            x_calc   = XW'(tone_sel) + XW'(j_reg) - XW'(1);
        end
        else
        begin
            tone_sel = start_tones_reg[11*k_reg +: 11];
            x_calc   = XW'(tone_sel) + sl14 + XW'(pos_sel);
        end

        sum5       = acc_reg + ACC_W'(rd_data_reg);
        total_next = total_reg + 33'(quot);
        fail_next  = fail_reg || ((k_reg >= 3'd1) && (k_reg <= 3'd3) && (quot <= 30'd2));
        need       = (start_mode_reg == stsd_pkg::MODE_X25) ? 3'd5 : 3'd4;
        start_ok   = hits_reg >= need;
        dev10      = {{3{search_low_reg[6]}}, search_low_reg} + 10'(best_pos_reg);
        red_pos    = !red_reg[28] && (red_reg != '0);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        root_start = 1'b0;
        div_start  = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        done_fire  = 1'b0;
        case (state_reg)
            stsd_pkg::ST_IDLE:
                if (bin_valid)
                    state_next = stsd_pkg::ST_MUL_RE;
            stsd_pkg::ST_MUL_RE:
                state_next = stsd_pkg::ST_MUL_IM;
            stsd_pkg::ST_MUL_IM:
            begin
                root_start = 1'b1;
                state_next = stsd_pkg::ST_ROOT;
            end
            stsd_pkg::ST_ROOT:
                if (root_done)
                begin
                    wr_en      = in_window;
                    state_next = last_reg ? stsd_pkg::ST_SETUP : stsd_pkg::ST_IDLE;
                end
            stsd_pkg::ST_SETUP:
                state_next = win_ok ? stsd_pkg::ST_AIM : stsd_pkg::ST_DONE;
            stsd_pkg::ST_AIM:
                state_next = stsd_pkg::ST_ADDR;
            stsd_pkg::ST_ADDR:
                // The index is folded into the memory range one step a cycle.
                if (!x_reg[XW-1] && (x_reg < XW'(MAX_BINS)))
                begin
                    rd_en      = 1'b1;
                    state_next = stsd_pkg::ST_USE;
                end
            stsd_pkg::ST_USE:
                case (phase_reg)
                    stsd_pkg::PH_CHECK:
                        state_next = stsd_pkg::ST_CMP;
                    stsd_pkg::PH_STOP:
                        state_next = ((k_reg == 3'd4) && (j_reg == 2'd2)) ?
                                     stsd_pkg::ST_DEN : stsd_pkg::ST_AIM;
                    default:
                        state_next = stsd_pkg::ST_AIM;
                endcase
            stsd_pkg::ST_CMP:
                if (k_reg == 3'd4)
                    state_next = big_n_reg ? stsd_pkg::ST_AIM : stsd_pkg::ST_DONE;
                else
                    state_next = stsd_pkg::ST_AIM;
            stsd_pkg::ST_DEN:
                state_next = red_pos ? stsd_pkg::ST_NUM : stsd_pkg::ST_DONE;
            stsd_pkg::ST_NUM:
                state_next = stsd_pkg::ST_DIV;
            stsd_pkg::ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = stsd_pkg::ST_DIVW;
            end
            stsd_pkg::ST_DIVW:
                if (div_done)
                    state_next = (k_reg == 3'd4) ? stsd_pkg::ST_DONE : stsd_pkg::ST_NUM;
            stsd_pkg::ST_DONE:
                if (!out_valid_reg || !result_stall)
                begin
                    done_fire  = 1'b1;
                    state_next = stsd_pkg::ST_IDLE;
                end
            default:
                state_next = stsd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= stsd_pkg::ST_IDLE;
            cnt_reg          <= '0;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
            wf_reg           <= 11'd0;
            wl_reg           <= 11'd2047;
            start_tones_reg  <= '0;
            stop_tones_reg   <= '0;
            search_low_reg   <= '0;
            search_count_reg <= 8'd1;
            start_mode_reg   <= 2'd1;
            stop_mode_reg    <= 2'd1;
        end
        else
        begin
            state_reg <= state_next;

            if (wr_en)
                sum_reg <= sum_reg + stsd_pkg::SUM_W'(root);
            if (state_reg == stsd_pkg::ST_ROOT && root_done && !last_reg)
                cnt_reg <= (cnt_reg == AW'(MAX_BINS - 1)) ? '0 : cnt_reg + AW'(1);
            if (done_fire)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end

            if (done_fire)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    stsd_pkg::CFG_WINDOW_FIRST:    wf_reg           <= cfg_data[10:0];
                    stsd_pkg::CFG_WINDOW_LAST:     wl_reg           <= cfg_data[10:0];
                    stsd_pkg::CFG_START_TONE_BINS: start_tones_reg  <= cfg_data;
                    stsd_pkg::CFG_STOP_TONE_BINS:  stop_tones_reg   <= cfg_data;
                    stsd_pkg::CFG_SEARCH_LOW:      search_low_reg   <= cfg_data[6:0];
                    stsd_pkg::CFG_SEARCH_COUNT:    search_count_reg <= cfg_data[7:0];
                    stsd_pkg::CFG_START_MODE:      start_mode_reg   <= cfg_data[1:0];
                    stsd_pkg::CFG_STOP_MODE:       stop_mode_reg    <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Magnitude memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mag_mem[cnt_reg] <= root;
        if (rd_en)
            rd_data_reg <= mag_mem[x_reg[AW-1:0]];
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            stsd_pkg::ST_IDLE:
                if (bin_valid)
                begin
                    re_reg   <= bin.bin_real;
                    im_reg   <= bin.bin_imag;
                    last_reg <= bin.last_bin;
                end
            stsd_pkg::ST_MUL_RE:
                pw_reg <= 32'(sq);
            stsd_pkg::ST_SETUP:
            begin
                win_ok_reg   <= win_ok;
                n2_reg       <= {n12, 1'b0};
                n2m_reg      <= {n12 - 12'd15, 1'b0};
                big_n_reg    <= n12 > 12'd15;
                s_cs_reg     <= scale_mul({1'b0, sum_reg}, start_mode_reg);
                red_reg      <= {1'b0, sum_reg};
                cnt_eff_reg  <= PW'(cnt_eff9);
                pos_reg      <= '0;
                best_pos_reg <= '0;
                best_reg     <= '0;
                acc_reg      <= '0;
                k_reg        <= '0;
                j_reg        <= '0;
                hits_reg     <= '0;
                phase_reg    <= stsd_pkg::PH_SEARCH;
                total_reg    <= '0;
                fail_reg     <= 1'b0;
                stop_ok_reg  <= 1'b0;
            end
            stsd_pkg::ST_AIM:
                x_reg <= x_calc;
            stsd_pkg::ST_ADDR:
                if (x_reg[XW-1])
                    x_reg <= x_reg + XW'(MAX_BINS);
                else if (x_reg >= XW'(MAX_BINS))
                    x_reg <= x_reg - XW'(MAX_BINS);
            stsd_pkg::ST_USE:
                case (phase_reg)
                    stsd_pkg::PH_CHECK:
                        prod_reg <= 30'(rd_data_reg) * 30'(n2_reg);
                    stsd_pkg::PH_STOP:
                    begin
                        red_reg <= red_reg - 29'(rd_data_reg);
                        if (j_reg == 2'd1)
                            stop_mag[k_reg] <= rd_data_reg;
                        if (j_reg == 2'd2)
                        begin
                            j_reg <= '0;
                            k_reg <= (k_reg == 3'd4) ? 3'd0 : k_reg + 3'd1;
                        end
                        else
                            j_reg <= j_reg + 2'd1;
                    end
                    default:
                        if (k_reg != 3'd4)
                        begin
                            acc_reg <= sum5;
                            k_reg   <= k_reg + 3'd1;
                        end
                        else
                        begin
                            // Strictly greater keeps the first maximum.
                            if (sum5 > best_reg)
                            begin
                                best_reg     <= sum5;
                                best_pos_reg <= pos_reg;
                            end
                            acc_reg <= '0;
                            k_reg   <= '0;
                            if (pos_reg == cnt_eff_reg - PW'(1))
                                phase_reg <= stsd_pkg::PH_CHECK;
                            else
                                pos_reg <= pos_reg + PW'(1);
                        end
                endcase
            stsd_pkg::ST_CMP:
            begin
                if (31'(prod_reg) > s_cs_reg)
                    hits_reg <= hits_reg + 3'd1;
                if (k_reg == 3'd4)
                begin
                    k_reg     <= '0;
                    phase_reg <= stsd_pkg::PH_STOP;
                end
                else
                    k_reg <= k_reg + 3'd1;
            end
            stsd_pkg::ST_DEN:
                den_reg <= scale_mul(red_reg, stop_mode_reg);
            stsd_pkg::ST_NUM:
                num_reg <= 30'(stop_mag[k_reg]) * 30'(n2m_reg);
            stsd_pkg::ST_DIVW:
                if (div_done)
                begin
                    total_reg <= total_next;
                    fail_reg  <= fail_next;
                    if (k_reg == 3'd4)
                        stop_ok_reg <= (total_next > 33'd8) && !fail_next;
                    else
                        k_reg <= k_reg + 3'd1;
                end
            default: ;
        endcase

        if (done_fire)
        begin
            out_data_reg.start_found <= win_ok_reg && start_ok;
            out_data_reg.deviation   <= (win_ok_reg && start_ok) ? dev10[7:0] : 8'sd0;
            out_data_reg.stop_found  <= win_ok_reg && stop_ok_reg;
        end
    end

    assign bin_stall    = state_reg != stsd_pkg::ST_IDLE;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    `STSD_ASSERT_IMP(a_root_done_in_wait, clk, rst_n, root_done, state_reg == stsd_pkg::ST_ROOT)
    `STSD_ASSERT_IMP(a_div_done_in_wait, clk, rst_n, div_done, state_reg == stsd_pkg::ST_DIVW)
    `STSD_ASSERT_NEXT(a_frame_cleared, clk, rst_n, done_fire, (cnt_reg == '0) && (sum_reg == '0))
    `STSD_ASSERT_NEXT(a_result_loaded, clk, rst_n, done_fire, out_valid_reg)

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spectral tone set detector testbench
// Streams frames of FFT bins under varied window, tone and mode settings,
// predicts the start and stop decisions of each frame and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int NBINS       = 2048;
    localparam int NSEARCH     = 128;
    localparam int IDLE_LIMIT  = 20000;
    localparam int ITEM_TARGET = 1550;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              bin_valid = 1'b0;
    logic              bin_stall;
    stsd_pkg::bin_t    bin_req = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    stsd_pkg::result_t result;
    logic              cfg_we = 1'b0;
    logic [stsd_pkg::CFG_IDX_W-1:0]  cfg_index = stsd_pkg::CFG_WINDOW_FIRST;
    logic [stsd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state and register copies
    int unsigned       mags [NBINS];
    logic [27:0]       wsum = '0;
    logic [10:0]       bcount = '0;
    logic [10:0]       wfirst = 11'd0;
    logic [10:0]       wlast = 11'd2047;
    logic [54:0]       start_bins = '0;
    logic [54:0]       stop_bins = '0;
    logic signed [6:0] search_lo = '0;
    logic [7:0]        search_cnt = 8'd1;
    logic [1:0]        start_md = 2'd1;
    logic [1:0]        stop_md = 2'd1;

    stsd_pkg::bin_t    bins_pending [$];
    stsd_pkg::result_t decisions_due [$];
    int                issued = 0;
    int                accepted = 0;
    int                errors = 0;
    int                gap = 0;
    int                stall_left = 0;
    int                idle_cycles = 0;
    int                pushed = 0;
    bit                no_gaps = 1'b0;
    bit                stop_loud = 1'b0;
    int                loud_dev = 0;

    spectral_tone_set_detector uut (
        .clk(clk), .rst_n(rst_n),
        .bin_valid(bin_valid), .bin_stall(bin_stall), .bin(bin_req),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return int'(r);
    endfunction

    function automatic longint unsigned mag_at(int x);
        return mags[((x % NBINS) + NBINS) % NBINS];
    endfunction

    function automatic int tone_of(logic [54:0] packed_bins, int k);
        return int'(packed_bins[11*k +: 11]);
    endfunction

    function automatic longint unsigned scale_of(logic [1:0] md);
        if (md == stsd_pkg::MODE_X15)
            return 3;
        if (md == stsd_pkg::MODE_X25)
            return 5;
        return 2;
    endfunction

    // Updates the model with one accepted bin; a last bin yields a decision.
    task automatic take_bin(stsd_pkg::bin_t b);
        longint re;
        longint im;
        int unsigned m;
        longint unsigned n;
        longint unsigned s;
        longint unsigned cs;
        longint unsigned den;
        longint unsigned q [5];
        longint unsigned total;
        longint unsigned acc;
        longint unsigned best_sum;
        longint r;
        int cnt;
        int best_pos;
        int hits;
        int need;
        int sl;
        stsd_pkg::result_t d;
        re = b.bin_real;
        im = b.bin_imag;
        m = int_root(longint'(re * re + im * im));
        if (bcount >= wfirst && bcount <= wlast)
        begin
            mags[bcount] = m;
            wsum = wsum + 28'(m);
        end
        if (!b.last_bin)
        begin
            bcount = bcount + 11'd1;
            return;
        end
        d = '0;
        if (wfirst <= wlast)
        begin
            n = wlast - wfirst + 1;
            s = wsum;
            sl = search_lo;
            cnt = (search_cnt == 0) ? 1 : ((search_cnt > NSEARCH) ? NSEARCH : search_cnt);
            best_sum = 0;
            best_pos = 0;
            for (int p = 0; p < cnt; p++)
            begin
                acc = 0;
                for (int k = 0; k < 5; k++)
                    acc += mag_at(tone_of(start_bins, k) + sl + p);
                if (acc > best_sum)
                begin
                    best_sum = acc;
                    best_pos = p;
                end
            end
            cs = scale_of(start_md);
            need = (start_md == stsd_pkg::MODE_X25) ? 5 : 4;
            hits = 0;
            for (int k = 0; k < 5; k++)
                if (mag_at(tone_of(start_bins, k) + sl + best_pos) * 2 * n > s * cs)
                    hits++;
            if (hits >= need)
            begin
                d.start_found = 1'b1;
                d.deviation = 8'(sl + best_pos);
            end
            if (n > 15)
            begin
                r = longint'(s);
                for (int k = 0; k < 5; k++)
                    for (int j = -1; j <= 1; j++)
                        r -= longint'(mag_at(tone_of(stop_bins, k) + j));
                if (r > 0)
                begin
                    den = longint'(r) * scale_of(stop_md);
                    total = 0;
                    for (int k = 0; k < 5; k++)
                    begin
                        q[k] = mag_at(tone_of(stop_bins, k)) * 2 * (n - 15) / den;
                        total += q[k];
                    end
                    if (total > 8 && q[1] > 2 && q[2] > 2 && q[3] > 2)
                        d.stop_found = 1'b1;
                end
            end
        end
        decisions_due.push_back(d);
        wsum = '0;
        bcount = '0;
    endtask

    // Bin driver: handles the request that was just accepted, then offers the next.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (bin_valid && !bin_stall)
            begin
                take_bin(bin_req);
                accepted++;
            end
            if (bin_valid && bin_stall)
                bin_valid <= 1'b1;
            else if (gap > 0)
            begin
                bin_valid <= 1'b0;
                gap--;
            end
            else if (bins_pending.size() > 0)
            begin
                bin_req <= bins_pending.pop_front();
                bin_valid <= 1'b1;
                issued++;
                gap = no_gaps ? 0 : $urandom_range(0, 16);
            end
            else
                bin_valid <= 1'b0;
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (decisions_due.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, result);
                    errors++;
                end
                else
                begin
                    stsd_pkg::result_t e;
                    e = decisions_due.pop_front();
                    if (result.start_found !== e.start_found)
                    begin
                        $display("%0t: start_found expected %0b actual %0b",
                                 $time, e.start_found, result.start_found);
                        errors++;
                    end
                    if (result.deviation !== e.deviation)
                    begin
                        $display("%0t: deviation expected %0d actual %0d",
                                 $time, e.deviation, result.deviation);
                        errors++;
                    end
                    if (result.stop_found !== e.stop_found)
                    begin
                        $display("%0t: stop_found expected %0b actual %0b",
                                 $time, e.stop_found, result.stop_found);
                        errors++;
                    end
                end
                stall_left = no_gaps ? 0 : $urandom_range(0, 16);
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog on cycles in which no request moves on either channel.
    always @(posedge clk)
    begin
        if ((bin_valid && !bin_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("spectral_tone_set_detector test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic put_reg(logic [stsd_pkg::CFG_IDX_W-1:0] idx, logic [54:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            stsd_pkg::CFG_WINDOW_FIRST:    wfirst = v[10:0];
            stsd_pkg::CFG_WINDOW_LAST:     wlast = v[10:0];
            stsd_pkg::CFG_START_TONE_BINS: start_bins = v;
            stsd_pkg::CFG_STOP_TONE_BINS:  stop_bins = v;
            stsd_pkg::CFG_SEARCH_LOW:      search_lo = v[6:0];
            stsd_pkg::CFG_SEARCH_COUNT:    search_cnt = v[7:0];
            stsd_pkg::CFG_START_MODE:      start_md = v[1:0];
            default:                       stop_md = v[1:0];
        endcase
    endtask

    function automatic logic signed [15:0] pick_part(bit loud);
        logic signed [15:0] v;
        if ($urandom_range(0, 19) == 0)
            return 16'($urandom);
        v = loud ? 16'($urandom_range(8000, 32767)) : 16'($urandom_range(0, 200));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Queues one frame; loud bins: start tones + planted offset, stop tones if stop_loud.
    task automatic queue_frame(int len);
        stsd_pkg::bin_t b;
        bit loud;
        for (int i = 0; i < len; i++)
        begin
            loud = 1'b0;
            for (int k = 0; k < 5; k++)
            begin
                if (i == (((tone_of(start_bins, k) + loud_dev) % NBINS) + NBINS) % NBINS)
                    loud = 1'b1;
                if (stop_loud && i == tone_of(stop_bins, k))
                    loud = 1'b1;
            end
            b.bin_real = pick_part(loud);
            b.bin_imag = pick_part(loud);
            b.last_bin = (i == len - 1);
            bins_pending.push_back(b);
        end
        pushed += len;
    endtask

    task automatic wait_idle();
        wait (bins_pending.size() == 0 && accepted == issued && decisions_due.size() == 0);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [54:0] tone_row(int base, int step);
        logic [54:0] v;
        for (int k = 0; k < 5; k++)
            v[11*k +: 11] = 11'(base + k * step);
        return v;
    endfunction

    initial
    begin
        stsd_pkg::bin_t b;
        int span;
        int cnt;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // A full-width first frame writes every stored magnitude before any test reads one.
        put_reg(stsd_pkg::CFG_WINDOW_FIRST, 55'd0);
        put_reg(stsd_pkg::CFG_WINDOW_LAST, 55'd2047);
        put_reg(stsd_pkg::CFG_START_TONE_BINS, {55{1'b1}});
        put_reg(stsd_pkg::CFG_STOP_TONE_BINS, {55{1'b1}});
        put_reg(stsd_pkg::CFG_SEARCH_LOW, 55'(7'h40));
        put_reg(stsd_pkg::CFG_SEARCH_COUNT, 55'd255);
        put_reg(stsd_pkg::CFG_START_MODE, 55'd0);
        put_reg(stsd_pkg::CFG_STOP_MODE, 55'd0);
        no_gaps = 1'b1;
        b = '{16'sh8000, 16'sh8000, 1'b0};
        bins_pending.push_back(b);
        b = '{16'sh7fff, 16'sh7fff, 1'b0};
        bins_pending.push_back(b);
        b = '{16'sh7fff, 16'sh8000, 1'b0};
        bins_pending.push_back(b);
        b = '{16'sh0000, 16'sh0000, 1'b0};
        bins_pending.push_back(b);
        loud_dev = 0;
        stop_loud = 1'b0;
        queue_frame(NBINS - 4);
        wait_idle();
        no_gaps = 1'b0;

        // Empty window, search count of zero.
        put_reg(stsd_pkg::CFG_WINDOW_FIRST, 55'd2047);
        put_reg(stsd_pkg::CFG_WINDOW_LAST, 55'd0);
        put_reg(stsd_pkg::CFG_SEARCH_COUNT, 55'd0);
        queue_frame(3);
        wait_idle();

        // Strong five-tone frame with the strictest modes, then a 15-bin window.
        put_reg(stsd_pkg::CFG_WINDOW_FIRST, 55'd0);
        put_reg(stsd_pkg::CFG_WINDOW_LAST, 55'd30);
        put_reg(stsd_pkg::CFG_START_TONE_BINS, tone_row(4, 3));
        put_reg(stsd_pkg::CFG_STOP_TONE_BINS, tone_row(5, 4));
        put_reg(stsd_pkg::CFG_SEARCH_LOW, 55'd0);
        put_reg(stsd_pkg::CFG_SEARCH_COUNT, 55'd128);
        put_reg(stsd_pkg::CFG_START_MODE, 55'(stsd_pkg::MODE_X25));
        put_reg(stsd_pkg::CFG_STOP_MODE, 55'(stsd_pkg::MODE_X25));
        stop_loud = 1'b1;
        queue_frame(31);
        wait_idle();
        put_reg(stsd_pkg::CFG_WINDOW_LAST, 55'd14);
        queue_frame(15);
        queue_frame(1);
        wait_idle();

        while (pushed < NBINS + ITEM_TARGET)
        begin
            put_reg(stsd_pkg::CFG_WINDOW_FIRST, 55'($urandom_range(0, 8)));
            put_reg(stsd_pkg::CFG_WINDOW_LAST, 55'(wfirst + $urandom_range(0, 50)));
            if ($urandom_range(0, 9) == 0)
                put_reg(stsd_pkg::CFG_WINDOW_FIRST, 55'(wlast + $urandom_range(1, 4)));
            span = (wlast > wfirst) ? wlast - wfirst : 1;
            if ($urandom_range(0, 4) == 0)
                put_reg(stsd_pkg::CFG_START_TONE_BINS, 55'({$urandom, $urandom}));
            else
                put_reg(stsd_pkg::CFG_START_TONE_BINS,
                        tone_row(wfirst + $urandom_range(0, span / 2), $urandom_range(1, 6)));
            if ($urandom_range(0, 4) == 0)
                put_reg(stsd_pkg::CFG_STOP_TONE_BINS, 55'({$urandom, $urandom}));
            else
                put_reg(stsd_pkg::CFG_STOP_TONE_BINS,
                        tone_row(wfirst + $urandom_range(1, span / 3 + 1), $urandom_range(3, 6)));
            put_reg(stsd_pkg::CFG_SEARCH_LOW, 55'(7'(-$urandom_range(0, 64))));
            case ($urandom_range(0, 19))
                0:       put_reg(stsd_pkg::CFG_SEARCH_COUNT, 55'd0);
                1:       put_reg(stsd_pkg::CFG_SEARCH_COUNT, 55'd128);
                2:       put_reg(stsd_pkg::CFG_SEARCH_COUNT, 55'd255);
                3:       put_reg(stsd_pkg::CFG_SEARCH_COUNT, 55'($urandom_range(0, 255)));
                default: put_reg(stsd_pkg::CFG_SEARCH_COUNT, 55'($urandom_range(1, 16)));
            endcase
            put_reg(stsd_pkg::CFG_START_MODE, 55'($urandom_range(0, 3)));
            put_reg(stsd_pkg::CFG_STOP_MODE, 55'($urandom_range(0, 3)));
            cnt = (search_cnt == 0) ? 1 : ((search_cnt > NSEARCH) ? NSEARCH : search_cnt);
            loud_dev = int'(search_lo) + $urandom_range(0, cnt - 1);
            stop_loud = ($urandom_range(0, 9) < 6);
            no_gaps = ($urandom_range(0, 5) == 0);
            repeat ($urandom_range(1, 3))
                queue_frame(($urandom_range(0, 5) == 0) ? $urandom_range(1, 60)
                                                        : wlast + 1 + $urandom_range(0, 5));
            wait_idle();
        end

        if (errors == 0)
            $display("spectral_tone_set_detector test passed");
        else
            $display("spectral_tone_set_detector test failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/stsd_pkg.sv
rtl/core/stsd_isqrt.sv
rtl/core/stsd_div.sv
rtl/core/spectral_tone_set_detector.sv
tb/tb_top.sv
